[rtl/core/mesh_vertex_weld_compact_macros.svh]
// Assertion macros used by the mesh vertex weld sequencer.
`ifndef MESH_VERTEX_WELD_COMPACT_MACROS_SVH
`define MESH_VERTEX_WELD_COMPACT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MVW_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MVW_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/mvw_pkg.sv]
// Types and constants of the mesh vertex weld block.
package mvw_pkg;

    localparam int ADDR_W = 16;
    localparam int CNT_W  = 17;

    localparam logic [1:0] FN_LOAD_KEY = 2'd0;
    localparam logic [1:0] FN_LOAD_IDX = 2'd1;
    localparam logic [1:0] FN_RUN      = 2'd2;
    localparam logic [1:0] FN_READ     = 2'd3;

    localparam logic [2:0] ST_NO_DUP   = 3'd0;
    localparam logic [2:0] ST_WELDED   = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE,
        S_READ,
        S_CHK_RD,
        S_CHK_EX,
        S_REP_V,
        S_REP_VC,
        S_REP_U_RD,
        S_REP_U_EX,
        S_CLR,
        S_MAP_RD,
        S_MAP_IDX,
        S_MAP_REP,
        S_CMP_RD,
        S_CMP_EX,
        S_NUM_RD,
        S_NUM_IDX,
        S_NUM_POS
    } mvw_state_t;

    typedef struct packed {
        logic              key_we;
        logic [ADDR_W-1:0] key_waddr;
        logic [63:0]       key_wh;
        logic [31:0]       key_wl;
        logic [ADDR_W-1:0] key_raddr;
        logic              idx_we;
        logic [ADDR_W-1:0] idx_waddr;
        logic [15:0]       idx_wdata;
        logic [ADDR_W-1:0] idx_raddr;
        logic              rep_we;
        logic [ADDR_W-1:0] rep_waddr;
        logic [ADDR_W-1:0] rep_wdata;
        logic [ADDR_W-1:0] rep_raddr;
        logic              pos_we;
        logic [ADDR_W-1:0] pos_waddr;
        logic [ADDR_W-1:0] pos_wdata;
        logic [ADDR_W-1:0] pos_raddr;
        logic              mark_we;
        logic [ADDR_W-1:0] mark_waddr;
        logic              mark_wdata;
        logic [ADDR_W-1:0] mark_raddr;
    } mvw_mem_req_t;

    typedef struct packed {
        logic [63:0]       key_h;
        logic [31:0]       key_l;
        logic [15:0]       idx;
        logic [ADDR_W-1:0] rep;
        logic [ADDR_W-1:0] pos;
        logic              mark;
    } mvw_mem_rsp_t;

    typedef struct packed {
        logic        valid;
        logic [2:0]  status;
        logic        dup;
        logic [10:0] vcount;
        logic [15:0] idx;
        logic [63:0] key_h;
        logic [31:0] key_l;
    } mvw_res_t;

endpackage

[rtl/core/mesh_vertex_weld_compact.sv]
// Top level of the mesh vertex weld block: handshake, output register, sequencer, stores.
//
// Input channel in_valid/in_ready carries one command word: func selects
// load vertex key, load index, run weld or read result slot. Loads give no
// result. A read gives one result word through the S_READ state and the
// output register. A run gives one status word when the sequencer is done.
// Run time is set by the single key comparator walking the vertex store:
// an index range check, then the lowest-match key scan, then clear,
// remap, compaction and renumber passes when duplicates exist.
// Failed checks return early with no store changed.
// in_ready is low while a run or read is in progress, and low for runs
// and reads while a result word waits; loads are still taken then.
// Output channel out_valid/out_ready holds the result word in a register
// until taken; a stalled receiver only blocks further runs and reads.
// Reset clears counts, overflow flag and last status; store contents are
// undefined until loaded.
module mesh_vertex_weld_compact
    import mvw_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_INDICES  = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [63:0] key_high,
    input  logic [31:0] key_low,
    input  logic [15:0] index_value,
    input  logic [11:0] read_slot,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic        duplicate_found,
    output logic [10:0] vertex_count_out,
    output logic [15:0] index_out,
    output logic [63:0] key_high_out,
    output logic [31:0] key_low_out
);

    mvw_mem_req_t req;
    mvw_mem_rsp_t rsp;
    mvw_res_t     res;
    logic         idle;
    logic         is_load;
    logic         start;
    logic         out_valid_reg, out_valid_next;
    mvw_res_t     out_reg, out_next;

    assign is_load  = (func == FN_LOAD_KEY) || (func == FN_LOAD_IDX);
    assign in_ready = idle && (!out_valid_reg || out_ready || is_load);
    assign start    = in_valid && in_ready;

    mvw_seq #(
        .MAX_VERTICES(MAX_VERTICES),
        .MAX_INDICES (MAX_INDICES)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .func       (func),
        .key_high   (key_high),
        .key_low    (key_low),
        .index_value(index_value),
        .read_slot  (read_slot),
        .idle       (idle),
        .res        (res),
        .req        (req),
        .rsp        (rsp)
    );

    mvw_stores #(
        .MAX_VERTICES(MAX_VERTICES),
        .MAX_INDICES (MAX_INDICES)
    ) u_stores (
        .clk(clk),
        .req(req),
        .rsp(rsp)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res.valid)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid        = out_valid_reg;
    assign status           = out_reg.status;
    assign duplicate_found  = out_reg.dup;
    assign vertex_count_out = out_reg.vcount;
    assign index_out        = out_reg.idx;
    assign key_high_out     = out_reg.key_h;
    assign key_low_out      = out_reg.key_l;

endmodule

[rtl/core/mvw_stores.sv]
// Vertex key, index, map and mark memories, one write and one read port each.
module mvw_stores
    import mvw_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_INDICES  = 4096
)
(
    input  logic         clk,
    input  mvw_mem_req_t req,
    output mvw_mem_rsp_t rsp
);

    localparam int VA_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int IA_W = (MAX_INDICES > 1) ? $clog2(MAX_INDICES) : 1;

    logic [63:0]     key_h_mem [MAX_VERTICES];
    logic [31:0]     key_l_mem [MAX_VERTICES];
    logic [15:0]     idx_mem   [MAX_INDICES];
    logic [VA_W-1:0] rep_mem   [MAX_VERTICES];
    logic [VA_W-1:0] pos_mem   [MAX_VERTICES];
    logic            mark_mem  [MAX_VERTICES];

    always_ff @(posedge clk)
    begin
        if (req.key_we)
        begin
            key_h_mem[req.key_waddr[VA_W-1:0]] <= req.key_wh;
            key_l_mem[req.key_waddr[VA_W-1:0]] <= req.key_wl;
        end
        rsp.key_h <= key_h_mem[req.key_raddr[VA_W-1:0]];
        rsp.key_l <= key_l_mem[req.key_raddr[VA_W-1:0]];

        if (req.idx_we)
        begin
            idx_mem[req.idx_waddr[IA_W-1:0]] <= req.idx_wdata;
        end
        rsp.idx <= idx_mem[req.idx_raddr[IA_W-1:0]];

        if (req.rep_we)
        begin
            rep_mem[req.rep_waddr[VA_W-1:0]] <= req.rep_wdata[VA_W-1:0];
        end
        rsp.rep <= ADDR_W'(rep_mem[req.rep_raddr[VA_W-1:0]]);

        if (req.pos_we)
        begin
            pos_mem[req.pos_waddr[VA_W-1:0]] <= req.pos_wdata[VA_W-1:0];
        end
        rsp.pos <= ADDR_W'(pos_mem[req.pos_raddr[VA_W-1:0]]);

        if (req.mark_we)
        begin
            mark_mem[req.mark_waddr[VA_W-1:0]] <= req.mark_wdata;
        end
        rsp.mark <= mark_mem[req.mark_raddr[VA_W-1:0]];
    end

endmodule

[rtl/core/mvw_seq.sv]
// Weld sequencer: loads, checks, key compare scan, remap, compaction and reads.
`include "mesh_vertex_weld_compact_macros.svh"

module mvw_seq
    import mvw_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_INDICES  = 4096
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [1:0]   func,
    input  logic [63:0]  key_high,
    input  logic [31:0]  key_low,
    input  logic [15:0]  index_value,
    input  logic [11:0]  read_slot,
    output logic         idle,
    output mvw_res_t     res,
    output mvw_mem_req_t req,
    input  mvw_mem_rsp_t rsp
);

    localparam logic [CNT_W-1:0] VMAX = CNT_W'(MAX_VERTICES);
    localparam logic [CNT_W-1:0] IMAX = CNT_W'(MAX_INDICES);
    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

    mvw_state_t state_reg, state_next;
    logic [CNT_W-1:0] vcnt_reg, vcnt_next;
    logic [CNT_W-1:0] icnt_reg, icnt_next;
    logic             ovf_reg, ovf_next;
    logic [2:0]       last_status_reg, last_status_next;
    logic             last_dup_reg, last_dup_next;
    logic             dup_reg, dup_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] v_reg, v_next;
    logic [CNT_W-1:0] u_reg, u_next;
    logic [CNT_W-1:0] ret_reg, ret_next;
    logic [63:0]      kvh_reg, kvh_next;
    logic [31:0]      kvl_reg, kvl_next;
    logic [11:0]      slot_reg, slot_next;

    logic             hit;
    logic             i_last;
    logic             v_last;

    assign hit    = (rsp.key_h == kvh_reg) && (rsp.key_l == kvl_reg);
    assign i_last = (i_reg + ONE) == icnt_reg;
    assign v_last = (v_reg + ONE) == vcnt_reg;
    assign idle   = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            vcnt_reg        <= '0;
            icnt_reg        <= '0;
            ovf_reg         <= 1'b0;
            last_status_reg <= ST_NO_DUP;
            last_dup_reg    <= 1'b0;
            dup_reg         <= 1'b0;
            i_reg           <= '0;
            v_reg           <= '0;
            u_reg           <= '0;
            ret_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            vcnt_reg        <= vcnt_next;
            icnt_reg        <= icnt_next;
            ovf_reg         <= ovf_next;
            last_status_reg <= last_status_next;
            last_dup_reg    <= last_dup_next;
            dup_reg         <= dup_next;
            i_reg           <= i_next;
            v_reg           <= v_next;
            u_reg           <= u_next;
            ret_reg         <= ret_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kvh_reg  <= kvh_next;
        kvl_reg  <= kvl_next;
        slot_reg <= slot_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        vcnt_next        = vcnt_reg;
        icnt_next        = icnt_reg;
        ovf_next         = ovf_reg;
        last_status_next = last_status_reg;
        last_dup_next    = last_dup_reg;
        dup_next         = dup_reg;
        i_next           = i_reg;
        v_next           = v_reg;
        u_next           = u_reg;
        ret_next         = ret_reg;
        kvh_next         = kvh_reg;
        kvl_next         = kvl_reg;
        slot_next        = slot_reg;
        req              = '0;
        res              = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (func)
                        FN_LOAD_KEY:
                        begin
                            if (vcnt_reg < VMAX)
                            begin
                                req.key_we    = 1'b1;
                                req.key_waddr = vcnt_reg[ADDR_W-1:0];
                                req.key_wh    = key_high;
                                req.key_wl    = key_low;
                                vcnt_next     = vcnt_reg + ONE;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        FN_LOAD_IDX:
                        begin
                            if (icnt_reg < IMAX)
                            begin
                                req.idx_we    = 1'b1;
                                req.idx_waddr = icnt_reg[ADDR_W-1:0];
                                req.idx_wdata = index_value;
                                icnt_next     = icnt_reg + ONE;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        FN_RUN:
                        begin
                            dup_next = 1'b0;
                            i_next   = '0;
                            if (vcnt_reg == '0 || icnt_reg == '0)
                            begin
                                res.valid        = 1'b1;
                                res.status       = ST_EMPTY;
                                res.vcount       = vcnt_reg[10:0];
                                last_status_next = ST_EMPTY;
                                last_dup_next    = 1'b0;
                            end
                            else if (ovf_reg)
                            begin
                                res.valid        = 1'b1;
                                res.status       = ST_OVERFLOW;
                                res.vcount       = vcnt_reg[10:0];
                                last_status_next = ST_OVERFLOW;
                                last_dup_next    = 1'b0;
                            end
                            else
                            begin
                                state_next = S_CHK_RD;
                            end
                        end
                        FN_READ:
                        begin
                            req.idx_raddr = ADDR_W'(read_slot);
                            req.key_raddr = ADDR_W'(read_slot);
                            slot_next     = read_slot;
                            state_next    = S_READ;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res.valid  = 1'b1;
                res.status = last_status_reg;
                res.dup    = last_dup_reg;
                res.vcount = vcnt_reg[10:0];
                if (CNT_W'(slot_reg) < icnt_reg)
                begin
                    res.idx = rsp.idx;
                end
                if (CNT_W'(slot_reg) < vcnt_reg)
                begin
                    res.key_h = rsp.key_h;
                    res.key_l = rsp.key_l;
                end
                state_next = S_IDLE;
            end
            S_CHK_RD:
            begin
                req.idx_raddr = i_reg[ADDR_W-1:0];
                state_next    = S_CHK_EX;
            end
            S_CHK_EX:
            begin
                if (CNT_W'(rsp.idx) >= vcnt_reg)
                begin
                    res.valid        = 1'b1;
                    res.status       = ST_RANGE;
                    res.vcount       = vcnt_reg[10:0];
                    last_status_next = ST_RANGE;
                    last_dup_next    = 1'b0;
                    state_next       = S_IDLE;
                end
                else if (i_last)
                begin
                    v_next     = '0;
                    state_next = S_REP_V;
                end
                else
                begin
                    i_next     = i_reg + ONE;
                    state_next = S_CHK_RD;
                end
            end
            S_REP_V:
            begin
                req.key_raddr = v_reg[ADDR_W-1:0];
                state_next    = S_REP_VC;
            end
            S_REP_VC:
            begin
                kvh_next   = rsp.key_h;
                kvl_next   = rsp.key_l;
                u_next     = '0;
                state_next = S_REP_U_RD;
            end
            S_REP_U_RD:
            begin
                if (u_reg == v_reg)
                begin
                    req.rep_we    = 1'b1;
                    req.rep_waddr = v_reg[ADDR_W-1:0];
                    req.rep_wdata = v_reg[ADDR_W-1:0];
                    if (v_last)
                    begin
                        if (dup_reg)
                        begin
                            v_next     = '0;
                            state_next = S_CLR;
                        end
                        else
                        begin
                            res.valid        = 1'b1;
                            res.status       = ST_NO_DUP;
                            res.vcount       = vcnt_reg[10:0];
                            last_status_next = ST_NO_DUP;
                            last_dup_next    = 1'b0;
                            state_next       = S_IDLE;
                        end
                    end
                    else
                    begin
                        v_next     = v_reg + ONE;
                        state_next = S_REP_V;
                    end
                end
                else
                begin
                    req.key_raddr = u_reg[ADDR_W-1:0];
                    state_next    = S_REP_U_EX;
                end
            end
            S_REP_U_EX:
            begin
                if (hit)
                begin
                    req.rep_we    = 1'b1;
                    req.rep_waddr = v_reg[ADDR_W-1:0];
                    req.rep_wdata = u_reg[ADDR_W-1:0];
                    dup_next      = 1'b1;
                    if (v_last)
                    begin
                        v_next     = '0;
                        state_next = S_CLR;
                    end
                    else
                    begin
                        v_next     = v_reg + ONE;
                        state_next = S_REP_V;
                    end
                end
                else
                begin
                    u_next     = u_reg + ONE;
                    state_next = S_REP_U_RD;
                end
            end
            S_CLR:
            begin
                req.mark_we    = 1'b1;
                req.mark_waddr = v_reg[ADDR_W-1:0];
                req.mark_wdata = 1'b0;
                if (v_last)
                begin
                    i_next     = '0;
                    state_next = S_MAP_RD;
                end
                else
                begin
                    v_next = v_reg + ONE;
                end
            end
            S_MAP_RD:
            begin
                req.idx_raddr = i_reg[ADDR_W-1:0];
                state_next    = S_MAP_IDX;
            end
            S_MAP_IDX:
            begin
                req.rep_raddr = rsp.idx;
                state_next    = S_MAP_REP;
            end
            S_MAP_REP:
            begin
                req.idx_we     = 1'b1;
                req.idx_waddr  = i_reg[ADDR_W-1:0];
                req.idx_wdata  = rsp.rep;
                req.mark_we    = 1'b1;
                req.mark_waddr = rsp.rep;
                req.mark_wdata = 1'b1;
                if (i_last)
                begin
                    v_next     = '0;
                    ret_next   = '0;
                    state_next = S_CMP_RD;
                end
                else
                begin
                    i_next     = i_reg + ONE;
                    state_next = S_MAP_RD;
                end
            end
            S_CMP_RD:
            begin
                req.mark_raddr = v_reg[ADDR_W-1:0];
                req.key_raddr  = v_reg[ADDR_W-1:0];
                state_next     = S_CMP_EX;
            end
            S_CMP_EX:
            begin
                req.pos_we    = 1'b1;
                req.pos_waddr = v_reg[ADDR_W-1:0];
                if (rsp.mark)
                begin
                    req.pos_wdata = ret_reg[ADDR_W-1:0];
                    req.key_we    = 1'b1;
                    req.key_waddr = ret_reg[ADDR_W-1:0];
                    req.key_wh    = rsp.key_h;
                    req.key_wl    = rsp.key_l;
                    ret_next      = ret_reg + ONE;
                end
                if (v_last)
                begin
                    i_next     = '0;
                    state_next = S_NUM_RD;
                end
                else
                begin
                    v_next     = v_reg + ONE;
                    state_next = S_CMP_RD;
                end
            end
            S_NUM_RD:
            begin
                req.idx_raddr = i_reg[ADDR_W-1:0];
                state_next    = S_NUM_IDX;
            end
            S_NUM_IDX:
            begin
                req.pos_raddr = rsp.idx;
                state_next    = S_NUM_POS;
            end
            S_NUM_POS:
            begin
                req.idx_we    = 1'b1;
                req.idx_waddr = i_reg[ADDR_W-1:0];
                req.idx_wdata = rsp.pos;
                if (i_last)
                begin
                    vcnt_next        = ret_reg;
                    res.valid        = 1'b1;
                    res.status       = ST_WELDED;
                    res.dup          = 1'b1;
                    res.vcount       = ret_reg[10:0];
                    last_status_next = ST_WELDED;
                    last_dup_next    = 1'b1;
                    state_next       = S_IDLE;
                end
                else
                begin
                    i_next     = i_reg + ONE;
                    state_next = S_NUM_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `MVW_ASSERT_IMP(a_res_not_idle, res.valid && !start, state_reg != S_IDLE, "result out of idle")
    `MVW_ASSERT_IMP(a_vcnt_max, 1'b1, vcnt_reg <= VMAX, "vertex count above capacity")
    `MVW_ASSERT_IMP(a_ret_le_v, state_reg == S_CMP_EX, ret_reg <= v_reg, "compaction ahead of scan")
    `MVW_ASSERT_NXT(a_ovf_sticky, ovf_reg, ovf_reg, "overflow flag cleared")

endmodule

[sim/mesh_vertex_weld_compact_tb.sv]
// Testbench for mesh_vertex_weld_compact: random mesh loads, weld runs and readback vs a predictor.
module mesh_vertex_weld_compact_tb;
    import mvw_pkg::*;

    localparam int VMAX = 1024;
    localparam int IMAX = 4096;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int ITEM_TARGET = 950;

    typedef struct {
        logic [2:0]  st;
        logic        dup;
        logic [10:0] vc;
        logic [15:0] ix;
        logic [63:0] kh;
        logic [31:0] kl;
    } weld_word_t;

    class weld_scoreboard;
        logic [63:0] kh[VMAX];
        logic [31:0] kl[VMAX];
        logic [15:0] ix[IMAX];
        int          vcount;
        int          icount;
        bit          ovf;
        logic [2:0]  last_st;
        logic        last_dup;
        weld_word_t  pending[$];
        int          errors;

        function new();
            vcount = 0;
            icount = 0;
            ovf = 0;
            last_st = ST_NO_DUP;
            last_dup = 0;
            errors = 0;
        endfunction

        function logic [2:0] weld(output logic dup);
            int rep[VMAX];
            int pos[VMAX];
            bit mark[VMAX];
            int kept;
            dup = 0;
            if (vcount == 0 || icount == 0) return ST_EMPTY;
            if (ovf) return ST_OVERFLOW;
            for (int i = 0; i < icount; i++)
                if (ix[i] >= vcount) return ST_RANGE;
            for (int v = 0; v < vcount; v++)
            begin
                rep[v] = v;
                for (int u = 0; u < v; u++)
                    if (kh[u] == kh[v] && kl[u] == kl[v])
                    begin
                        rep[v] = u;
                        dup = 1;
                        break;
                    end
            end
            if (!dup) return ST_NO_DUP;
            for (int v = 0; v < VMAX; v++) mark[v] = 0;
            for (int i = 0; i < icount; i++)
            begin
                ix[i] = 16'(rep[ix[i]]);
                mark[ix[i]] = 1;
            end
            kept = 0;
            for (int v = 0; v < vcount; v++)
                if (mark[v])
                begin
                    pos[v] = kept;
                    kh[kept] = kh[v];
                    kl[kept] = kl[v];
                    kept++;
                end
                else
                    pos[v] = 0;
            for (int i = 0; i < icount; i++) ix[i] = 16'(pos[ix[i]]);
            vcount = kept;
            return ST_WELDED;
        endfunction

        function void note(logic [1:0] f, logic [63:0] h, logic [31:0] l,
                           logic [15:0] iv, logic [11:0] slot);
            weld_word_t w;
            logic d;
            case (f)
                FN_LOAD_KEY:
                    if (vcount < VMAX)
                    begin
                        kh[vcount] = h;
                        kl[vcount] = l;
                        vcount++;
                    end
                    else
                        ovf = 1;
                FN_LOAD_IDX:
                    if (icount < IMAX)
                    begin
                        ix[icount] = iv;
                        icount++;
                    end
                    else
                        ovf = 1;
                FN_RUN:
                begin
                    last_st = weld(d);
                    last_dup = d;
                    w.st = last_st;
                    w.dup = last_dup;
                    w.vc = 11'(vcount);
                    w.ix = 0;
                    w.kh = 0;
                    w.kl = 0;
                    pending.push_back(w);
                end
                default:
                begin
                    w.st = last_st;
                    w.dup = last_dup;
                    w.vc = 11'(vcount);
                    w.ix = (slot < icount) ? ix[slot] : 16'd0;
                    w.kh = (slot < vcount) ? kh[slot] : 64'd0;
                    w.kl = (slot < vcount) ? kl[slot] : 32'd0;
                    pending.push_back(w);
                end
            endcase
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check(weld_word_t got);
            weld_word_t e;
            if (pending.size() == 0)
            begin
                report("result word with none expected");
                return;
            end
            e = pending.pop_front();
            if (got.st !== e.st) report($sformatf("status %0d exp %0d", got.st, e.st));
            if (got.dup !== e.dup) report($sformatf("dup %0d exp %0d", got.dup, e.dup));
            if (got.vc !== e.vc) report($sformatf("vcount %0d exp %0d", got.vc, e.vc));
            if (got.ix !== e.ix) report($sformatf("index %0d exp %0d", got.ix, e.ix));
            if (got.kh !== e.kh) report($sformatf("key_h %h exp %h", got.kh, e.kh));
            if (got.kl !== e.kl) report($sformatf("key_l %h exp %h", got.kl, e.kl));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [63:0] key_high;
    logic [31:0] key_low;
    logic [15:0] index_value;
    logic [11:0] read_slot;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic        duplicate_found;
    logic [10:0] vertex_count_out;
    logic [15:0] index_out;
    logic [63:0] key_high_out;
    logic [31:0] key_low_out;

    weld_scoreboard sb;
    bit          quiet;
    int          cycles;
    int          items;
    int          stall_left;
    logic [63:0] pool_h[12];
    logic [31:0] pool_l[12];

    mesh_vertex_weld_compact DUT (.*);

    initial clk = 0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 9);
            out_ready <= 0;
        end
        else
            out_ready <= 1;
    end

    always @(posedge clk)
    begin
        weld_word_t w;
        if (rst_n && out_valid && out_ready)
        begin
            w.st = status;
            w.dup = duplicate_found;
            w.vc = vertex_count_out;
            w.ix = index_out;
            w.kh = key_high_out;
            w.kl = key_low_out;
            sb.check(w);
        end
    end

    task send(logic [1:0] f, logic [63:0] h, logic [31:0] l, logic [15:0] iv,
              logic [11:0] slot);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        func <= f;
        key_high <= h;
        key_low <= l;
        index_value <= iv;
        read_slot <= slot;
        in_valid <= 1;
        do @(posedge clk); while (!in_ready);
        sb.note(f, h, l, iv, slot);
        items++;
        @(negedge clk);
    endtask

    task load_key(logic [63:0] h, logic [31:0] l);
        send(FN_LOAD_KEY, h, l, $urandom, $urandom);
    endtask

    task load_idx(logic [15:0] iv);
        send(FN_LOAD_IDX, {$urandom, $urandom}, $urandom, iv, $urandom);
    endtask

    task run_weld();
        send(FN_RUN, {$urandom, $urandom}, $urandom, $urandom, $urandom);
    endtask

    task read_back(logic [11:0] slot);
        send(FN_READ, {$urandom, $urandom}, $urandom, $urandom, slot);
    endtask

    task drain();
        in_valid <= 0;
        while (sb.pending.size() > 0) @(negedge clk);
    endtask

    task mesh_phase();
        int nk;
        int ni;
        int nr;
        int p;
        int top;
        nk = $urandom_range(1, 5);
        for (int k = 0; k < nk; k++)
        begin
            p = $urandom_range(0, 11);
            if ($urandom_range(0, 9) < 8) load_key(pool_h[p], pool_l[p]);
            else load_key({$urandom, $urandom}, $urandom);
        end
        ni = $urandom_range(1, 6);
        for (int i = 0; i < ni; i++)
            if ($urandom_range(0, 39) == 0) load_idx(sb.vcount + $urandom_range(0, 2));
            else load_idx($urandom_range(0, sb.vcount - 1));
        run_weld();
        nr = $urandom_range(0, 8);
        top = (sb.vcount > sb.icount ? sb.vcount : sb.icount) + 1;
        for (int r = 0; r < nr; r++)
            if ($urandom_range(0, 7) == 0) read_back($urandom_range(0, 4095));
            else read_back($urandom_range(0, top));
    endtask

    initial
    begin
        int phase;
        sb = new();
        quiet = 0;
        cycles = 0;
        items = 0;
        stall_left = 0;
        rst_n = 0;
        in_valid = 0;
        out_ready = 0;
        func = FN_LOAD_KEY;
        key_high = 0;
        key_low = 0;
        index_value = 0;
        read_slot = 0;
        for (int i = 0; i < 12; i++)
        begin
            pool_h[i] = (i % 3 == 0) ? 64'h0123_4567_89ab_cdef : {$urandom, $urandom};
            pool_l[i] = {2'($urandom_range(0, 3)), 30'h0};
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed
        read_back(0);
        run_weld();
        load_key('1, '1);
        load_key('0, '0);
        run_weld();
        load_idx(0);
        load_idx(1);
        run_weld();
        read_back(0);
        read_back(1);
        read_back(4095);
        load_key('1, '1);
        load_key('1, 32'h0);
        load_idx(2);
        load_idx(3);
        run_weld();
        read_back(0);
        read_back(1);
        read_back(2);
        load_idx(3);
        run_weld();
        read_back(3);
        load_key(64'h8000_0000_0000_0000, 32'h8000_0001);
        run_weld();
        drain();

        phase = 0;
        while (items < ITEM_TARGET)
        begin
            if (items > ITEM_TARGET * 9 / 10) quiet = 1;
            mesh_phase();
            phase++;
            if (phase % 15 == 0) drain();
        end

        // poisoned index, then vertex store overflow: both last since they stick
        load_idx(16'hffff);
        run_weld();
        read_back(sb.icount - 1);
        while (sb.vcount < VMAX) load_key({$urandom, $urandom}, $urandom);
        load_key({$urandom, $urandom}, $urandom);
        run_weld();
        read_back(VMAX - 1);
        read_back(4095);
        in_valid <= 0;

        while (sb.pending.size() > 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/mvw_pkg.sv
rtl/core/mvw_stores.sv
rtl/core/mvw_seq.sv
rtl/core/mesh_vertex_weld_compact.sv
sim/mesh_vertex_weld_compact_tb.sv
